[rtl/pnv_pkg.sv]
// Shared types, constants and a helper function for the pixel stream to NV21 converter.
`default_nettype none

package pnv_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam int DIM_W  = 12;
	localparam int COL_W  = 11;
	localparam int OFF_W  = 23;
	localparam int PAIR_W = 22;
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 4;
	localparam int APB_W  = 32;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FORMAT = 2'd2;

	typedef enum logic [1:0] {
		FMT_GRAY = 2'd0,
		FMT_RGB  = 2'd1,
		FMT_NV21 = 2'd2,
		FMT_NV12 = 2'd3
	} fmt_t;

	// Reset values of the registers and of the derived frame sizes.
	localparam logic [DIM_W-1:0]  RST_WIDTH  = 12'd640;
	localparam logic [DIM_W-1:0]  RST_HEIGHT = 12'd480;
	localparam fmt_t              RST_FMT    = FMT_RGB;
	localparam int                RST_FS_INT = 640 * 480;
	localparam logic [OFF_W-1:0]  RST_FS     = OFF_W'(RST_FS_INT);
	localparam logic [PAIR_W-1:0] RST_TOTAL  = PAIR_W'((RST_FS_INT / 4) * 3);

	// Number of bytes one word produces.
	localparam logic [1:0] CNT_ONE   = 2'd1;
	localparam logic [1:0] CNT_TWO   = 2'd2;
	localparam logic [1:0] CNT_THREE = 2'd3;

	// Position of the byte being sent within one word's set.
	localparam logic [1:0] SEL_FIRST  = 2'd0;
	localparam logic [1:0] SEL_SECOND = 2'd1;

	typedef struct packed {
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [OFF_W-1:0]  luma_size;
		logic [PAIR_W-1:0] pair_total;
		fmt_t              fmt;
	} pnv_cfg_t;

	typedef struct packed {
		logic              pair_mode;
		logic              gray;
		logic              swap;
		logic              chroma;
		logic              last_frame;
		logic [BYTE_W-1:0] a;
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] c;
		logic [OFF_W-1:0]  y_off;
		logic [OFF_W-1:0]  vu_off;
	} pnv_item_t;

	typedef struct packed {
		logic [1:0]        count;
		logic              last_frame;
		logic [OFF_W-1:0]  off0;
		logic [OFF_W-1:0]  off1;
		logic [BYTE_W-1:0] d0;
		logic [BYTE_W-1:0] d1;
		logic [BYTE_W-1:0] d2;
	} pnv_set_t;

	// Clear bit 0 and clamp the dimension to [2, maxv].
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] v;
		v = raw & 12'hFFE;
		if (v > maxv) begin
			v = maxv;
		end
		if (v < 12'd2) begin
			v = 12'd2;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/pnv_stream_if.sv]
// Handshake interfaces for the source word channel and the NV21 byte channel.
`default_nettype none

interface pnv_pix_if import pnv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] first_byte;
	logic [BYTE_W-1:0] second_byte;
	logic [BYTE_W-1:0] third_byte;

	modport source (output valid, output first_byte, output second_byte,
		output third_byte, input ready);
	modport sink (input valid, input first_byte, input second_byte,
		input third_byte, output ready);
endinterface

interface pnv_nv_if import pnv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OFF_W-1:0]  byte_offset;
	logic [BYTE_W-1:0] out_data;
	logic              last_of_item;
	logic              last_of_frame;

	modport source (output valid, output byte_offset, output out_data,
		output last_of_item, output last_of_frame, input ready);
	modport sink (input valid, input byte_offset, input out_data,
		input last_of_item, input last_of_frame, output ready);
endinterface

`default_nettype wire

[rtl/pnv_cfg.sv]
// Configuration registers, effective frame sizes and the settle window after a write.
`default_nettype none

module pnv_cfg import pnv_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [APB_W-1:0]  pwdata,
	output logic      [APB_W-1:0]  prdata,
	output logic                   pready,
	output pnv_cfg_t               cfg,
	output logic                   clear,
	output logic                   busy
);

	localparam logic [1:0] SETTLE_CYCLES = 2'd2;

	logic [DIM_W-1:0]  width_raw_q;
	logic [DIM_W-1:0]  height_raw_q;
	fmt_t              fmt_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [OFF_W-1:0]  fs_q;
	logic [PAIR_W-1:0] total_q;
	logic [1:0]        settle_q;
	logic [1:0]        idx;
	logic              wr;
	logic [2*DIM_W-1:0] fs_full;
	logic [OFF_W-1:0]  total_full;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel & penable & pwrite & pready;
	assign clear  = wr & ((idx == REG_WIDTH) || (idx == REG_HEIGHT) || (idx == REG_FORMAT));
	assign busy   = (settle_q != 2'd0);

	// Frame size is one register behind the dimensions, the pair count one more.
	assign fs_full    = width_q * height_q;
	assign total_full = {2'b00, fs_q[OFF_W-1:2]} + {1'b0, fs_q[OFF_W-1:2], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_raw_q  <= RST_WIDTH;
			height_raw_q <= RST_HEIGHT;
			fmt_q        <= RST_FMT;
			width_q      <= RST_WIDTH;
			height_q     <= RST_HEIGHT;
			fs_q         <= RST_FS;
			total_q      <= RST_TOTAL;
			settle_q     <= 2'd0;
		end else begin
			fs_q    <= fs_full[OFF_W-1:0];
			total_q <= total_full[PAIR_W-1:0];
			if (wr) begin
				unique case (idx)
					REG_WIDTH: begin
						width_raw_q <= pwdata[DIM_W-1:0];
						width_q     <= eff_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_WIDTH));
					end
					REG_HEIGHT: begin
						height_raw_q <= pwdata[DIM_W-1:0];
						height_q     <= eff_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
					end
					REG_FORMAT: begin
						fmt_q <= fmt_t'(pwdata[1:0]);
					end
					default: begin
					end
				endcase
			end
			if (clear) begin
				settle_q <= SETTLE_CYCLES;
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = {{(APB_W-DIM_W){1'b0}}, width_raw_q};
			REG_HEIGHT: prdata = {{(APB_W-DIM_W){1'b0}}, height_raw_q};
			REG_FORMAT: prdata = {{(APB_W-2){1'b0}}, fmt_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.width      = width_q;
	assign cfg.height     = height_q;
	assign cfg.luma_size  = fs_q;
	assign cfg.pair_total = total_q;
	assign cfg.fmt        = fmt_q;

endmodule

`default_nettype wire

[rtl/pnv_addr.sv]
// Raster position counters and the NV21 offsets of the word being accepted.
`default_nettype none

module pnv_addr import pnv_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pnv_cfg_t          cfg,
	input  wire logic              clear,
	input  wire logic              accept,
	input  wire logic [BYTE_W-1:0] first_byte,
	input  wire logic [BYTE_W-1:0] second_byte,
	input  wire logic [BYTE_W-1:0] third_byte,
	output pnv_item_t              item
);

	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  row_q;
	logic [OFF_W-1:0]  y_off_q;
	logic [PAIR_W-1:0] crow_q;
	logic [PAIR_W-1:0] pair_q;
	logic              pixel_mode;
	logic              col_end;
	logic              row_end;
	logic              pair_end;
	logic [OFF_W-1:0]  pair_off;

	assign pixel_mode = (cfg.fmt == FMT_GRAY) || (cfg.fmt == FMT_RGB);
	assign col_end    = (({1'b0, col_q} + 12'd1) == cfg.width);
	assign row_end    = (({1'b0, row_q} + 12'd1) == cfg.height);
	assign pair_end   = (pair_q == (cfg.pair_total - 22'd1));
	assign pair_off   = {pair_q, 1'b0};

	always_comb begin
		item.pair_mode  = ~pixel_mode;
		item.gray       = (cfg.fmt == FMT_GRAY);
		item.swap       = (cfg.fmt == FMT_NV12) && (pair_off >= cfg.luma_size);
		item.chroma     = ~row_q[0] & ~col_q[0];
		item.last_frame = pixel_mode ? (col_end & row_end) : pair_end;
		item.a          = first_byte;
		item.b          = second_byte;
		item.c          = third_byte;
		item.y_off      = pixel_mode ? y_off_q : pair_off;
		item.vu_off     = cfg.luma_size + {1'b0, crow_q} + {{(OFF_W-COL_W){1'b0}}, col_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			y_off_q <= '0;
			crow_q  <= '0;
			pair_q  <= '0;
		end else if (clear) begin
			col_q   <= '0;
			row_q   <= '0;
			y_off_q <= '0;
			crow_q  <= '0;
			pair_q  <= '0;
		end else if (accept) begin
			if (pixel_mode) begin
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q   <= '0;
						y_off_q <= '0;
						crow_q  <= '0;
					end else begin
						row_q   <= row_q + 11'd1;
						y_off_q <= y_off_q + 23'd1;
						// The chroma row advances when an odd row finishes.
						if (row_q[0]) begin
							crow_q <= crow_q + {{(PAIR_W-DIM_W){1'b0}}, cfg.width};
						end
					end
				end else begin
					col_q   <= col_q + 11'd1;
					y_off_q <= y_off_q + 23'd1;
				end
			end else begin
				pair_q <= pair_end ? '0 : pair_q + 22'd1;
			end
		end
	end

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, col_q} < cfg.width))
		else $error("column counter beyond frame width");
	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, row_q} < cfg.height))
		else $error("row counter beyond frame height");

endmodule

`default_nettype wire

[rtl/pnv_color.sv]
// BT.601 color conversion and assembly of the byte set that one word produces.
`default_nettype none

module pnv_color import pnv_pkg::*; (
	input  wire pnv_item_t item,
	output pnv_set_t       set
);

	logic [15:0]       y_sum;
	logic [15:0]       u_sum;
	logic [15:0]       v_sum;
	logic [BYTE_W-1:0] y_val;
	logic [BYTE_W-1:0] u_val;
	logic [BYTE_W-1:0] v_val;
	logic [15:0]       r16;
	logic [15:0]       g16;
	logic [15:0]       b16;

	assign r16 = {8'b0, item.a};
	assign g16 = {8'b0, item.b};
	assign b16 = {8'b0, item.c};

	// Sums wrap modulo 2^16; bits 15:8 give the floor shift modulo 256.
	assign y_sum = 16'd66 * r16 + 16'd129 * g16 + 16'd25 * b16 + 16'd128;
	assign u_sum = 16'd112 * b16 + 16'd128 - 16'd38 * r16 - 16'd74 * g16;
	assign v_sum = 16'd112 * r16 + 16'd128 - 16'd94 * g16 - 16'd18 * b16;

	always_comb begin
		if (item.gray) begin
			y_val = item.a;
			u_val = 8'd128;
			v_val = 8'd128;
		end else begin
			y_val = y_sum[15:8] + 8'd16;
			u_val = u_sum[15:8] + 8'd128;
			v_val = v_sum[15:8] + 8'd128;
		end

		set.last_frame = item.last_frame;
		set.off0       = item.y_off;
		if (item.pair_mode) begin
			set.count = CNT_TWO;
			set.off1  = item.y_off + 23'd1;
			set.d0    = item.swap ? item.b : item.a;
			set.d1    = item.swap ? item.a : item.b;
			set.d2    = '0;
		end else begin
			set.count = item.chroma ? CNT_THREE : CNT_ONE;
			set.off1  = item.vu_off;
			set.d0    = y_val;
			set.d1    = v_val;
			set.d2    = u_val;
		end
	end

endmodule

`default_nettype wire

[rtl/pnv_serial.sv]
// Result register holding one word's byte set and the output register that sends it.
`default_nettype none

module pnv_serial import pnv_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire pnv_set_t set,
	output logic          take,
	pnv_nv_if.source      nv
);

	pnv_set_t          set_s2;
	logic              valid_s2;
	logic [1:0]        idx_q;
	logic              out_valid_q;
	logic [OFF_W-1:0]  off_q;
	logic [BYTE_W-1:0] data_q;
	logic              loi_q;
	logic              lof_q;
	logic              out_free;
	logic              load;
	logic              last_pick;
	logic              s2_free;
	logic [OFF_W-1:0]  pick_off;
	logic [BYTE_W-1:0] pick_data;

	assign out_free  = ~out_valid_q | nv.ready;
	assign load      = valid_s2 & out_free;
	assign last_pick = (idx_q == (set_s2.count - 2'd1));
	assign s2_free   = ~valid_s2 | (load & last_pick);
	assign take      = in_valid & s2_free;

	always_comb begin
		case (idx_q)
			SEL_FIRST: begin
				pick_off  = set_s2.off0;
				pick_data = set_s2.d0;
			end
			SEL_SECOND: begin
				pick_off  = set_s2.off1;
				pick_data = set_s2.d1;
			end
			default: begin
				pick_off  = set_s2.off1 + 23'd1;
				pick_data = set_s2.d2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			idx_q       <= SEL_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s2 <= 1'b1;
				idx_q    <= SEL_FIRST;
			end else if (load & last_pick) begin
				valid_s2 <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (nv.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			set_s2 <= set;
		end
		if (load) begin
			off_q  <= pick_off;
			data_q <= pick_data;
			loi_q  <= last_pick;
			lof_q  <= last_pick & set_s2.last_frame;
		end
	end

	assign nv.valid         = out_valid_q;
	assign nv.byte_offset   = off_q;
	assign nv.out_data      = data_q;
	assign nv.last_of_item  = loi_q;
	assign nv.last_of_frame = lof_q;

	a_idx_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_q < set_s2.count))
		else $error("byte select beyond the size of the held set");
	a_frame_end_ends_word: assert property (@(posedge clk) disable iff (!arst_n)
		(nv.valid && nv.last_of_frame) |-> nv.last_of_item)
		else $error("frame end flagged on a byte that does not end its word");

endmodule

`default_nettype wire

[rtl/pixel_stream_to_nv21_top.sv]
// Top level of the pixel stream to NV21 converter.
`default_nettype none

// Converts a raster-ordered source stream into NV21 bytes, each tagged with its
// offset in the NV21 buffer (Y plane of width*height bytes, then the interleaved
// VU plane). In gray and rgb modes every input word is one pixel: it gives its Y
// byte, and on even rows and even columns also the V and then the U byte of its
// 2x2 block: in rgb mode by the BT.601 integer formulas with 8-bit wrap, in gray
// mode Y is the first byte and V and U are 128. In nv21 and nv12 modes a word is
// a byte pair passed through, with chroma pairs swapped in nv12 mode. Width and
// height have bit 0 cleared and are clamped to [2, 2048]. Any write to a defined
// register restarts the frame. A word is accepted every cycle as long as result
// bytes drain; the output carries one byte per cycle while ready. A pixel with
// chroma gives three bytes, any other pixel one and a pair two. Throughput is
// set by the single-byte output register, not by the conversion logic. An
// accepted word moves through the input, result and output registers. After a
// register write the input is held off while the frame size and the pair count
// of the new geometry are recomputed in registers.
module pixel_stream_to_nv21_top import pnv_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [APB_W-1:0]  pwdata,
	output logic      [APB_W-1:0]  prdata,
	output logic                   pready,
	pnv_pix_if.sink                pix,
	pnv_nv_if.source               nv
);

	pnv_cfg_t  cfg;
	pnv_item_t item;
	pnv_item_t item_s1;
	pnv_set_t  set;
	logic      clear;
	logic      busy;
	logic      accept;
	logic      valid_s1;
	logic      take;

	// Registers, derived frame sizes and the hold-off after a write.
	pnv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.clear   (clear),
		.busy    (busy)
	);

	// Unless busy, the input stage is free when empty or its word moves this cycle.
	assign pix.ready = ~busy & (~valid_s1 | take);
	assign accept    = pix.valid & pix.ready;

	// Position counters tag the incoming word with its offsets and frame flags.
	pnv_addr u_addr (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.clear       (clear),
		.accept      (accept),
		.first_byte  (pix.first_byte),
		.second_byte (pix.second_byte),
		.third_byte  (pix.third_byte),
		.item        (item)
	);

	// Input register: the accepted word with its position already resolved.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Color math between the input register and the result register.
	pnv_color u_color (
		.item (item_s1),
		.set  (set)
	);

	// Result register and the byte-wide output register.
	pnv_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.set      (set),
		.take     (take),
		.nv       (nv)
	);

endmodule

`default_nettype wire
